@@ rtl/core/cla_pkg.sv @@
// Types, constants and helper functions shared by the camera look-at block.
package cla_pkg;

    localparam int XY_W   = 50;
    localparam int Z_W    = 34;
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 50;
    localparam int DIV_QW = 15;

    localparam logic signed [Z_W-1:0]  ANG_PI      = 34'sd843314857;
    localparam logic signed [Z_W-1:0]  ANG_HALF_PI = 34'sd421657428;
    localparam logic signed [XY_W-1:0] CORDIC_K    = 50'sd652032874;
    localparam logic signed [31:0]     K_MUL       = 32'sd652032874;

    // Heights and horizontal distances, Q8.24.
    localparam longint C_TGT_H = 64'sd13421773;
    localparam longint C_OFS_N = 64'sd6710887;
    localparam longint C_HN    = 64'sd46988641;
    localparam longint C_ZN    = 64'sd14681806;
    localparam longint C_HS    = 64'sd46908501;
    localparam longint C_ZS    = 64'sd76255598;

    localparam logic signed [Z_W-1:0] YAW_LIM   = 34'sd205887;
    localparam logic signed [Z_W-1:0] PITCH_LIM = 34'sd102944;
    localparam logic [DIV_QW-1:0]     FWD_ONE   = 15'd16384;

    typedef enum logic [1:0] {
        CMD_POSE   = 2'd0,
        CMD_FOLLOW = 2'd1,
        CMD_STEEP  = 2'd2,
        CMD_OFFSET = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SC_GO, ST_SC_WAIT, ST_FM_C, ST_FM_S, ST_FM_END, ST_DELTA,
        ST_NORM, ST_V_GO, ST_V_WAIT, ST_MK_A, ST_MK_B, ST_MK_C, ST_FIN,
        ST_DIV_GO, ST_DIV_WAIT, ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic vec_mode;
    } t_cordic_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    function automatic logic signed [Z_W-1:0] atan_step(input logic [5:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            6'd0: v = 34'sd210828714;
            6'd1: v = 34'sd124459457;
            6'd2: v = 34'sd65760959;
            6'd3: v = 34'sd33381290;
            6'd4: v = 34'sd16755422;
            6'd5: v = 34'sd8385879;
            6'd6: v = 34'sd4193963;
            6'd7: v = 34'sd2097109;
            6'd8: v = 34'sd1048571;
            6'd9: v = 34'sd524287;
            default: begin
                if (i <= 6'd28) v = 34'sd1 <<< (6'd28 - i);
                else v = '0;
            end
        endcase
        return v;
    endfunction

    // Round-to-nearest right shift of an elaboration-time constant.
    function automatic longint rnd_const(input longint c, input int s);
        if (s <= 0) return c;
        return (c + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Q6.28 angle to Q18.16 with rounding, then clamped to the given limit.
    function automatic logic signed [Z_W-1:0] clamp_ang(input logic signed [Z_W-1:0] z,
                                                       input logic signed [Z_W-1:0] lim);
        logic signed [Z_W-1:0] r;
        r = (z + 34'sd2048) >>> 12;
        if (r > lim) return lim;
        if (r < -lim) return -lim;
        return r;
    endfunction

endpackage

@@ rtl/core/cla_cordic.sv @@
// Shared iterative CORDIC unit, rotation mode for sin/cos and vectoring mode for atan2.
module cla_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cla_pkg::t_cordic_cmd                i_cmd,
    input  logic signed [cla_pkg::XY_W-1:0]     i_x,
    input  logic signed [cla_pkg::XY_W-1:0]     i_y,
    input  logic signed [cla_pkg::Z_W-1:0]      i_z,
    output cla_pkg::t_unit_sts                  o_sts,
    output logic signed [cla_pkg::XY_W-1:0]     o_x,
    output logic signed [cla_pkg::XY_W-1:0]     o_y,
    output logic signed [cla_pkg::Z_W-1:0]      o_z
);
    localparam int IW = $clog2(STEPS);

    logic                            r_busy;
    logic                            r_done;
    logic [IW-1:0]                   r_i;
    logic                            r_vec;
    logic                            r_neg;
    logic signed [cla_pkg::XY_W-1:0] r_x;
    logic signed [cla_pkg::XY_W-1:0] r_y;
    logic signed [cla_pkg::Z_W-1:0]  r_z;

    logic signed [cla_pkg::XY_W-1:0] w_sx;
    logic signed [cla_pkg::XY_W-1:0] w_sy;
    logic signed [cla_pkg::Z_W-1:0]  w_a;
    logic                            w_pos;

    always_comb begin
        w_sx  = r_x >>> r_i;
        w_sy  = r_y >>> r_i;
        w_a   = cla_pkg::atan_step(6'(r_i));
        // Rotation steers on the residual angle, vectoring on the sign of y.
        w_pos = r_vec ? r_y[cla_pkg::XY_W-1] : ~r_z[cla_pkg::Z_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == IW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_vec <= i_cmd.vec_mode;
            if (i_cmd.vec_mode) begin
                r_neg <= 1'b0;
                if (i_x[cla_pkg::XY_W-1] && !i_y[cla_pkg::XY_W-1]) begin
                    r_x <= i_y;
                    r_y <= -i_x;
                    r_z <= cla_pkg::ANG_HALF_PI;
                end else if (i_x[cla_pkg::XY_W-1]) begin
                    r_x <= -i_y;
                    r_y <= i_x;
                    r_z <= -cla_pkg::ANG_HALF_PI;
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= i_z;
                end
            end else begin
                r_x <= cla_pkg::CORDIC_K;
                r_y <= '0;
                if (i_z > cla_pkg::ANG_HALF_PI) begin
                    r_z   <= i_z - cla_pkg::ANG_PI;
                    r_neg <= 1'b1;
                end else if (i_z < -cla_pkg::ANG_HALF_PI) begin
                    r_z   <= i_z + cla_pkg::ANG_PI;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= i_z;
                    r_neg <= 1'b0;
                end
            end
        end else if (r_busy) begin
            if (w_pos) begin
                r_x <= r_x - w_sy;
                r_y <= r_y + w_sx;
                r_z <= r_z - w_a;
            end else begin
                r_x <= r_x + w_sy;
                r_y <= r_y - w_sx;
                r_z <= r_z + w_a;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_x = r_neg ? -r_x : r_x;
    assign o_y = r_neg ? -r_y : r_y;
    assign o_z = r_z;

endmodule

@@ rtl/core/cla_div.sv @@
// Restoring divider for the forward components, one quotient bit per cycle.
module cla_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cla_pkg::DIV_NW-1:0]    i_num,
    input  logic [cla_pkg::DIV_DW-1:0]    i_den,
    output cla_pkg::t_unit_sts            o_sts,
    output logic [cla_pkg::DIV_QW-1:0]    o_quot
);
    localparam int QW = cla_pkg::DIV_QW;
    localparam int SW = cla_pkg::DIV_DW + QW + 1;

    logic                         r_busy;
    logic                         r_done;
    logic [3:0]                   r_cnt;
    logic [cla_pkg::DIV_NW-1:0]   r_rem;
    logic [SW-1:0]                r_dsh;
    logic [QW-1:0]                r_q;

    logic [SW-1:0]                w_lim;
    logic                         w_ge;

    assign w_lim = SW'(i_den) << QW;
    assign w_ge  = SW'(r_rem) >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // A zero length or a quotient of 2^15 or more needs no iterations.
                if (i_den == '0 || SW'(i_num) >= w_lim) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 4'(QW - 1);
                end
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= SW'(i_den) << (QW - 1);
            if (i_den == '0) r_q <= '0;
            else if (SW'(i_num) >= w_lim) r_q <= cla_pkg::FWD_ONE;
            else r_q <= '0;
        end else if (r_busy) begin
            if (w_ge) r_rem <= r_rem - r_dsh[cla_pkg::DIV_NW-1:0];
            r_q   <= {r_q[QW-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot = (r_q > cla_pkg::FWD_ONE) ? cla_pkg::FWD_ONE : r_q;

endmodule

@@ rtl/core/camera_look_at_orientation_top.sv @@
// Camera look-at orientation: pose state, sequencer and shared multiplier.
//
//  channel   direction  handshake                     payload
//  in        to block   i_in_valid / o_in_stall       command, flags, src, dst, heading, offset
//  out       from block o_out_valid / i_out_stall     eye, target, distance, yaw, pitch, forward
//
// Follow and steep commands first run a CORDIC rotation and the multiplier steps that
// place the eye. When the raised eye then sits on the target, the word goes straight
// to the output; otherwise normalize shifts run, then one or two CORDIC vectorings
// with a two-product gain correction, and three divisions, all on the shared CORDIC
// unit and divider. Reset clears the pose, the offset and the held angles; the input
// is stalled from acceptance until the result word is taken.
module camera_look_at_orientation_top #(
    parameter int CORDIC_STEPS           = 16,
    parameter int POSITION_FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic               i_write_eye,
    input  logic               i_write_target,
    input  logic signed [31:0] i_src_x,
    input  logic signed [31:0] i_src_y,
    input  logic signed [31:0] i_src_z,
    input  logic signed [31:0] i_dst_x,
    input  logic signed [31:0] i_dst_y,
    input  logic signed [31:0] i_dst_z,
    input  logic signed [18:0] i_heading,
    input  logic signed [31:0] i_offset_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_eye_out_x,
    output logic signed [31:0] o_eye_out_y,
    output logic signed [31:0] o_eye_out_z,
    output logic signed [31:0] o_target_out_x,
    output logic signed [31:0] o_target_out_y,
    output logic signed [31:0] o_target_out_z,
    output logic [30:0]        o_flat_distance,
    output logic signed [18:0] o_yaw_out,
    output logic signed [17:0] o_pitch_out,
    output logic signed [15:0] o_forward_x,
    output logic signed [15:0] o_forward_y,
    output logic signed [15:0] o_forward_z
);
    localparam int XY_W = cla_pkg::XY_W;
    localparam int Z_W  = cla_pkg::Z_W;
    localparam int CSH  = 24 - POSITION_FRACTION_BITS;
    localparam int FSH  = 54 - POSITION_FRACTION_BITS;

    localparam longint TGT_H = cla_pkg::rnd_const(cla_pkg::C_TGT_H, CSH);
    localparam longint OFS_N = cla_pkg::rnd_const(cla_pkg::C_OFS_N, CSH);
    localparam longint ZN    = cla_pkg::rnd_const(cla_pkg::C_ZN, CSH);
    localparam longint ZS    = cla_pkg::rnd_const(cla_pkg::C_ZS, CSH);

    cla_pkg::t_state r_state;
    cla_pkg::t_state n_state;

    logic [1:0]                r_cmd;
    logic signed [31:0]        r_src [3];
    logic signed [18:0]        r_heading;
    logic signed [31:0]        r_eye [3];
    logic signed [31:0]        r_tgt [3];
    logic signed [31:0]        r_ofs;
    logic signed [18:0]        r_yaw;
    logic signed [17:0]        r_pitch;
    logic [30:0]               r_dist;
    logic signed [15:0]        r_fwd [3];
    logic signed [47:0]        r_d [3];
    logic [5:0]                r_sh;
    logic                      r_flat;
    logic                      r_pass;
    logic [1:0]                r_didx;
    logic signed [31:0]        r_c;
    logic signed [31:0]        r_s;
    logic signed [XY_W-1:0]    r_mx;
    logic signed [Z_W-1:0]     r_ang2;
    logic [XY_W-1:0]           r_m1;
    logic [XY_W-1:0]           r_len;
    logic signed [63:0]        r_prod;
    logic signed [63:0]        r_acc;

    logic signed [31:0]        w_mul_a;
    logic signed [31:0]        w_mul_b;
    cla_pkg::t_cordic_cmd      w_ccmd;
    logic signed [XY_W-1:0]    w_cx0;
    logic signed [XY_W-1:0]    w_cy0;
    logic signed [Z_W-1:0]     w_cz0;
    cla_pkg::t_unit_sts        w_csts;
    logic signed [XY_W-1:0]    w_cx;
    logic signed [XY_W-1:0]    w_cy;
    logic signed [Z_W-1:0]     w_cz;
    logic                      w_dstart;
    logic [cla_pkg::DIV_NW-1:0] w_num;
    cla_pkg::t_unit_sts        w_dsts;
    logic [cla_pkg::DIV_QW-1:0] w_quot;
    logic                      w_accept;
    logic [47:0]               w_abs [3];
    logic [47:0]               w_m;
    logic [47:0]               w_dabs;
    logic signed [63:0]        w_prod_rnd;
    logic signed [63:0]        w_mk;
    logic [XY_W-1:0]           w_dr;
    logic [XY_W-1:0]           w_dd;
    logic signed [31:0]        w_hconst;
    logic signed [Z_W-1:0]     w_yaw;
    logic signed [Z_W-1:0]     w_pitch;

    assign w_accept = i_in_valid && !o_in_stall;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_abs[k] = r_d[k][47] ? 48'(-r_d[k]) : 48'(r_d[k]);
        end
        w_m = w_abs[0];
        if (w_abs[1] > w_m) w_m = w_abs[1];
        if (w_abs[2] > w_m) w_m = w_abs[2];
        w_dabs     = w_abs[r_didx];
        w_num      = (64'(w_dabs) << 14) + 64'(r_len >> 1);
        w_prod_rnd = (r_prod + (64'sd1 <<< (FSH - 1))) >>> FSH;
        w_mk       = (r_mx <= 0) ? 64'sd0 : r_acc + (r_prod >>> 30);
        w_dr       = r_m1 + ((r_sh == '0) ? '0 : (XY_W'(1) << (r_sh - 6'd1)));
        w_dd       = w_dr >> r_sh;
        w_hconst   = (r_cmd == cla_pkg::CMD_FOLLOW) ? 32'(cla_pkg::C_HN) : 32'(cla_pkg::C_HS);
        w_yaw      = cla_pkg::clamp_ang(w_cz, cla_pkg::YAW_LIM);
        w_pitch    = cla_pkg::clamp_ang(r_ang2, cla_pkg::PITCH_LIM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= cla_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state         = r_state;
        o_in_stall      = 1'b1;
        o_out_valid     = 1'b0;
        w_ccmd.start    = 1'b0;
        w_ccmd.vec_mode = 1'b1;
        w_cx0           = XY_W'(r_d[0]);
        w_cy0           = XY_W'(r_d[1]);
        w_cz0           = '0;
        w_dstart        = 1'b0;
        w_mul_a         = r_c;
        w_mul_b         = w_hconst;
        case (r_state)
            cla_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_command == cla_pkg::CMD_FOLLOW || i_command == cla_pkg::CMD_STEEP)
                        n_state = cla_pkg::ST_SC_GO;
                    else
                        n_state = cla_pkg::ST_DELTA;
                end
            end
            cla_pkg::ST_SC_GO: begin
                w_ccmd.start    = 1'b1;
                w_ccmd.vec_mode = 1'b0;
                w_cz0           = {{3{r_heading[18]}}, r_heading, 12'b0};
                n_state         = cla_pkg::ST_SC_WAIT;
            end
            cla_pkg::ST_SC_WAIT: if (w_csts.done) n_state = cla_pkg::ST_FM_C;
            cla_pkg::ST_FM_C:    n_state = cla_pkg::ST_FM_S;
            cla_pkg::ST_FM_S: begin
                w_mul_a = r_s;
                n_state = cla_pkg::ST_FM_END;
            end
            cla_pkg::ST_FM_END: n_state = cla_pkg::ST_DELTA;
            cla_pkg::ST_DELTA:  n_state = cla_pkg::ST_NORM;
            cla_pkg::ST_NORM: begin
                if (w_m == '0) n_state = cla_pkg::ST_OUT;
                else if (w_m >= 48'(1) << 43) n_state = cla_pkg::ST_V_GO;
            end
            cla_pkg::ST_V_GO: begin
                w_ccmd.start = 1'b1;
                if (r_pass) begin
                    w_cx0 = $signed(r_m1);
                    w_cy0 = XY_W'(r_d[2]);
                end
                n_state = cla_pkg::ST_V_WAIT;
            end
            cla_pkg::ST_V_WAIT: if (w_csts.done) n_state = cla_pkg::ST_MK_A;
            cla_pkg::ST_MK_A: begin
                w_mul_a = 32'(r_mx >>> 30);
                w_mul_b = cla_pkg::K_MUL;
                n_state = cla_pkg::ST_MK_B;
            end
            cla_pkg::ST_MK_B: begin
                w_mul_a = {2'b00, r_mx[29:0]};
                w_mul_b = cla_pkg::K_MUL;
                n_state = cla_pkg::ST_MK_C;
            end
            cla_pkg::ST_MK_C: n_state = r_pass ? cla_pkg::ST_FIN : cla_pkg::ST_V_GO;
            cla_pkg::ST_FIN:  n_state = cla_pkg::ST_DIV_GO;
            cla_pkg::ST_DIV_GO: begin
                w_dstart = 1'b1;
                n_state  = cla_pkg::ST_DIV_WAIT;
            end
            cla_pkg::ST_DIV_WAIT: begin
                if (w_dsts.done)
                    n_state = (r_didx == 2'd2) ? cla_pkg::ST_OUT : cla_pkg::ST_DIV_GO;
            end
            cla_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) n_state = cla_pkg::ST_IDLE;
            end
            default: n_state = cla_pkg::ST_IDLE;
        endcase
    end

    // Shared multiplier with its product register.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_eye[k] <= '0;
                r_tgt[k] <= '0;
            end
            r_ofs   <= '0;
            r_yaw   <= '0;
            r_pitch <= '0;
        end else begin
            case (r_state)
                cla_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        if (i_command == cla_pkg::CMD_POSE) begin
                            if (i_write_eye) begin
                                r_eye[0] <= i_src_x;
                                r_eye[1] <= i_src_y;
                                r_eye[2] <= i_src_z;
                            end
                            if (i_write_target) begin
                                r_tgt[0] <= i_dst_x;
                                r_tgt[1] <= i_dst_y;
                                r_tgt[2] <= i_dst_z;
                            end
                        end else if (i_command == cla_pkg::CMD_OFFSET) begin
                            r_ofs <= i_offset_value;
                        end
                    end
                end
                cla_pkg::ST_FM_S: begin
                    r_eye[0] <= cla_pkg::sat32(64'(r_src[0]) - w_prod_rnd);
                end
                cla_pkg::ST_FM_END: begin
                    r_eye[1] <= cla_pkg::sat32(64'(r_src[1]) - w_prod_rnd);
                    r_tgt[0] <= r_src[0];
                    r_tgt[1] <= r_src[1];
                    r_tgt[2] <= cla_pkg::sat32(64'(r_src[2]) + TGT_H);
                    if (r_cmd == cla_pkg::CMD_FOLLOW) begin
                        r_eye[2] <= cla_pkg::sat32(64'(r_src[2]) + ZN);
                        r_ofs    <= cla_pkg::sat32(OFS_N);
                    end else begin
                        r_eye[2] <= cla_pkg::sat32(64'(r_src[2]) + ZS);
                    end
                end
                cla_pkg::ST_V_WAIT: begin
                    if (w_csts.done && !r_pass) r_yaw <= w_yaw[18:0];
                end
                cla_pkg::ST_FIN: begin
                    if (r_flat) r_pitch <= w_pitch[17:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            cla_pkg::ST_IDLE: begin
                r_cmd     <= i_command;
                r_src[0]  <= i_src_x;
                r_src[1]  <= i_src_y;
                r_src[2]  <= i_src_z;
                r_heading <= i_heading;
            end
            cla_pkg::ST_SC_WAIT: begin
                r_c <= 32'(w_cx);
                r_s <= 32'(w_cy);
            end
            cla_pkg::ST_DELTA: begin
                r_d[0] <= 48'(r_tgt[0]) - 48'(r_eye[0]);
                r_d[1] <= 48'(r_tgt[1]) - 48'(r_eye[1]);
                r_d[2] <= 48'(r_tgt[2]) - 48'(r_eye[2]) - 48'(r_ofs);
                r_flat <= (r_tgt[0] != r_eye[0]) || (r_tgt[1] != r_eye[1]);
                r_sh   <= '0;
                r_pass <= 1'b0;
                r_dist <= '0;
            end
            cla_pkg::ST_NORM: begin
                if (w_m == '0) begin
                    for (int k = 0; k < 3; k++) r_fwd[k] <= '0;
                end else if (w_m < 48'(1) << 35) begin
                    // Far below the working range: take eight bits at once.
                    for (int k = 0; k < 3; k++) r_d[k] <= r_d[k] <<< 8;
                    r_sh <= r_sh + 6'd8;
                end else if (w_m < 48'(1) << 43) begin
                    for (int k = 0; k < 3; k++) r_d[k] <= r_d[k] <<< 1;
                    r_sh <= r_sh + 6'd1;
                end else if (!r_flat) begin
                    r_m1   <= '0;
                    r_pass <= 1'b1;
                end
            end
            cla_pkg::ST_V_WAIT: begin
                if (w_csts.done) begin
                    r_mx   <= w_cx;
                    r_ang2 <= w_cz;
                end
            end
            cla_pkg::ST_MK_B: r_acc <= r_prod;
            cla_pkg::ST_MK_C: begin
                if (r_pass) begin
                    r_len <= w_mk[XY_W-1:0];
                end else begin
                    r_m1   <= w_mk[XY_W-1:0];
                    r_pass <= 1'b1;
                end
            end
            cla_pkg::ST_FIN: begin
                r_didx <= '0;
                if (r_flat)
                    r_dist <= (w_dd > XY_W'(31'h7FFFFFFF)) ? 31'h7FFFFFFF : w_dd[30:0];
            end
            cla_pkg::ST_DIV_WAIT: begin
                if (w_dsts.done) begin
                    r_fwd[r_didx] <= r_d[r_didx][47] ? -16'(w_quot) : 16'(w_quot);
                    r_didx        <= r_didx + 2'd1;
                end
            end
            default: ;
        endcase
    end

    cla_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_ccmd),
        .i_x     (w_cx0),
        .i_y     (w_cy0),
        .i_z     (w_cz0),
        .o_sts   (w_csts),
        .o_x     (w_cx),
        .o_y     (w_cy),
        .o_z     (w_cz)
    );

    cla_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_num),
        .i_den   (r_len),
        .o_sts   (w_dsts),
        .o_quot  (w_quot)
    );

    assign o_eye_out_x     = r_eye[0];
    assign o_eye_out_y     = r_eye[1];
    assign o_eye_out_z     = r_eye[2];
    assign o_target_out_x  = r_tgt[0];
    assign o_target_out_y  = r_tgt[1];
    assign o_target_out_z  = r_tgt[2];
    assign o_flat_distance = r_dist;
    assign o_yaw_out       = r_yaw;
    assign o_pitch_out     = r_pitch;
    assign o_forward_x     = r_fwd[0];
    assign o_forward_y     = r_fwd[1];
    assign o_forward_z     = r_fwd[2];

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result word is pending");

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled after a word was taken");

    a_fwd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_forward_x <= 16'sd16384 && o_forward_x >= -16'sd16384 &&
                         o_forward_z <= 16'sd16384 && o_forward_z >= -16'sd16384))
        else $error("forward component out of range");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_yaw_out <= 19'sd205887 && o_yaw_out >= -19'sd205887))
        else $error("yaw out of range");

endmodule
